FILE: design/tba_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the target bearing block.
`timescale 1ns / 1ps

package tba_pkg;

    // CORDIC datapath widths: x/y carry the pre-shifted magnitudes, z is radians * 2^40.
    localparam int XY_W          = 64;
    localparam int Z_W           = 43;
    localparam int Z30_W         = 31;
    localparam int Z30_SHIFT     = 10;
    localparam int PROD_W        = 63;
    localparam int PRESHIFT_BASE = 59;
    localparam int PHI_LSB_BASE  = 56;
    localparam int PHI_EXTRA_W   = 7;
    localparam int BR_EXTRA_W    = 11;

    localparam int BEARING_W     = 18;

    localparam int DEG_90        = 90;
    localparam int DEG_180       = 180;

    // 180/pi scaled by 2^26.
    localparam logic [31:0] DEG_PER_RAD_Q26 = 32'd3845054675;
    // pi/2 scaled by 2^40.
    localparam logic [Z_W-1:0] Z_MAX        = 43'h1921FB54442;
    // Half an LSB of the 2^-30 radian grid.
    localparam logic [Z_W-1:0] Z_ROUND      = 43'd512;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam logic [QPTR_W:0] QUEUE_FULL_COUNT = (QPTR_W + 1)'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        KIND_GENERAL,
        KIND_HORIZ,
        KIND_VERT,
        KIND_ZERO
    } t_kind;

    typedef struct packed {
        logic  dx_neg;
        logic  dy_neg;
        t_kind kind;
    } t_class;

    // atan(2^-idx) in radians scaled by 2^40, rounded to nearest.
    function automatic logic [Z_W-1:0] atan_step(input int idx);
        logic [Z_W-1:0] v;
        case (idx)
            0:       v = 43'hC90FDAA221;
            1:       v = 43'd509785937287;
            2:       v = 43'd269356888665;
            3:       v = 43'd136729762476;
            4:       v = 43'd68630207382;
            5:       v = 43'd34348560106;
            6:       v = 43'd17178471287;
            7:       v = 43'd8589759836;
            8:       v = 43'd4294945451;
            9:       v = 43'd2147480917;
            10:      v = 43'd1073741483;
            11:      v = 43'd536870869;
            12:      v = 43'd268435451;
            13:      v = 43'd134217727;
            default: v = {{(Z_W - 1){1'b0}}, 1'b1} << (40 - idx);
        endcase
        return v;
    endfunction

endpackage

FILE: design/tba_coord_if.sv
// Handshake channel that carries one target and robot coordinate word.
`timescale 1ns / 1ps

interface tba_coord_if #(
    parameter int COORD_WIDTH = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] target_x;
    logic signed [COORD_WIDTH-1:0] target_y;
    logic signed [COORD_WIDTH-1:0] robot_x;
    logic signed [COORD_WIDTH-1:0] robot_y;

    modport source (
        output valid, target_x, target_y, robot_x, robot_y,
        input  ready
    );

    modport sink (
        input  valid, target_x, target_y, robot_x, robot_y,
        output ready
    );
endinterface

FILE: design/tba_bearing_if.sv
// Handshake channel that carries one bearing result word.
`timescale 1ns / 1ps

interface tba_bearing_if import tba_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [BEARING_W-1:0] bearing;
    logic                        invalid;

    modport source (
        output valid, bearing, invalid,
        input  ready
    );

    modport sink (
        input  valid, bearing, invalid,
        output ready
    );
endinterface

FILE: design/tba_front.sv
// Front end: takes coordinate words, forms the difference vector and classifies it.
`timescale 1ns / 1ps

module tba_front import tba_pkg::*; #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    tba_coord_if.sink              i_coord,
    input  logic                   i_full,
    output logic                   o_push,
    output logic [COORD_WIDTH:0]   o_ax,
    output logic [COORD_WIDTH:0]   o_ay,
    output t_class                 o_class
);

    localparam int AW = COORD_WIDTH + 1;

    logic                   r_valid;
    logic signed [AW-1:0]   r_dx;
    logic signed [AW-1:0]   r_dy;
    logic signed [AW-1:0]   n_dx;
    logic signed [AW-1:0]   n_dy;
    logic                   in_ready;

    assign in_ready      = !r_valid || !i_full;
    assign i_coord.ready = in_ready;
    assign o_push        = r_valid && !i_full;

    assign n_dx = {i_coord.target_x[COORD_WIDTH-1], i_coord.target_x}
                - {i_coord.robot_x[COORD_WIDTH-1], i_coord.robot_x};
    assign n_dy = {i_coord.target_y[COORD_WIDTH-1], i_coord.target_y}
                - {i_coord.robot_y[COORD_WIDTH-1], i_coord.robot_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_ready) begin
            r_valid <= i_coord.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_coord.valid && in_ready) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
    end

    // Magnitudes and quadrant signs; an axis-aligned vector skips the CORDIC result.
    always_comb begin
        o_ax           = r_dx[AW-1] ? AW'(-r_dx) : AW'(r_dx);
        o_ay           = r_dy[AW-1] ? AW'(-r_dy) : AW'(r_dy);
        o_class.dx_neg = r_dx[AW-1];
        o_class.dy_neg = r_dy[AW-1];
        if (r_dx == '0 && r_dy == '0) begin
            o_class.kind = KIND_ZERO;
        end else if (r_dy == '0) begin
            o_class.kind = KIND_HORIZ;
        end else if (r_dx == '0) begin
            o_class.kind = KIND_VERT;
        end else begin
            o_class.kind = KIND_GENERAL;
        end
    end

`ifndef SYNTH
    a_hold_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_full |=> r_valid && $stable(r_dx) && $stable(r_dy))
        else $error("front word changed while the queue was full");
`endif

endmodule

FILE: design/tba_queue.sv
// Short FIFO that decouples the classifying front end from the CORDIC back end.
`timescale 1ns / 1ps

module tba_queue import tba_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0]  r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W:0]   n_count;

    assign o_full  = r_count == QUEUE_FULL_COUNT;
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[QPTR_W-1:0] == QPTR_W'(r_wr_ptr - r_rd_ptr))
        else $error("queue fill count disagrees with the pointers");
`endif

endmodule

FILE: design/tba_back.sv
// Back end: unrolled CORDIC vectoring pipeline, degree conversion and quadrant folding.
`timescale 1ns / 1ps

module tba_back import tba_pkg::*; #(
    parameter int CORDIC_STAGES   = 20,
    parameter int COORD_WIDTH     = 24,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  logic [COORD_WIDTH:0] i_ax,
    input  logic [COORD_WIDTH:0] i_ay,
    input  t_class               i_class,
    output logic                 o_pop,
    tba_bearing_if.source        o_bearing
);

    localparam int NS       = CORDIC_STAGES;
    localparam int AW       = COORD_WIDTH + 1;
    localparam int PRESHIFT = PRESHIFT_BASE - COORD_WIDTH;
    localparam int PHI_W    = ANGLE_FRAC_BITS + PHI_EXTRA_W;
    localparam int PHI_LSB  = PHI_LSB_BASE - ANGLE_FRAC_BITS;
    localparam int BR_W     = ANGLE_FRAC_BITS + BR_EXTRA_W;
    localparam int EXT_W    = (BR_W > BEARING_W) ? BR_W : BEARING_W;

    localparam logic [PROD_W-1:0] PHI_ROUND = PROD_W'(1) << (PHI_LSB - 1);
    localparam logic [PHI_W-1:0]  PHI_90    = PHI_W'(DEG_90) << ANGLE_FRAC_BITS;
    localparam logic signed [BR_W-1:0] B90  = BR_W'(DEG_90) << ANGLE_FRAC_BITS;
    localparam logic signed [BR_W-1:0] B270 = BR_W'(DEG_90 + DEG_180) << ANGLE_FRAC_BITS;

    logic                     en;
    logic [NS+3:0]            r_v;
    t_class                   r_cls [0:NS+3];

    logic signed [XY_W-1:0]   r_x [0:NS-1];
    logic signed [XY_W-1:0]   r_y [0:NS-1];
    logic signed [XY_W-1:0]   n_x [1:NS-1];
    logic signed [XY_W-1:0]   n_y [1:NS-1];
    logic signed [XY_W-1:0]   x_sh [0:NS-2];
    logic signed [XY_W-1:0]   y_sh [0:NS-2];
    logic signed [Z_W-1:0]    r_z [0:NS];
    logic signed [Z_W-1:0]    n_z [1:NS];

    logic [Z_W-1:0]           z_clip;
    logic [Z_W-1:0]           z_rnd;
    logic [Z30_W-1:0]         r_z30;
    logic [PROD_W-1:0]        r_prod;
    logic [PROD_W-1:0]        phi_sum;
    logic [PHI_W-1:0]         phi_raw;
    logic [PHI_W-1:0]         phi_sat;
    logic [PHI_W-1:0]         r_phi;
    logic [PHI_W-1:0]         n_phi;
    logic signed [BR_W-1:0]   phi_s;
    logic signed [BR_W-1:0]   br;
    logic signed [EXT_W-1:0]  br_ext;

    logic                        r_out_valid;
    logic signed [BEARING_W-1:0] r_bearing;
    logic                        r_invalid;
    logic signed [BEARING_W-1:0] n_bearing;
    logic                        n_invalid;

    // The whole pipeline advances together whenever the output register can move.
    assign en    = !r_out_valid || o_bearing.ready;
    assign o_pop = en && !i_empty;

    assign o_bearing.valid   = r_out_valid;
    assign o_bearing.bearing = r_bearing;
    assign o_bearing.invalid = r_invalid;

    // Vectoring rotations: drive y toward zero, accumulate the angle in z.
    always_comb begin
        for (int i = 0; i < NS - 1; i++) begin
            x_sh[i] = r_x[i] >>> i;
            y_sh[i] = r_y[i] >>> i;
            if (!r_y[i][XY_W-1]) begin
                n_x[i+1] = r_x[i] + y_sh[i];
                n_y[i+1] = r_y[i] - x_sh[i];
            end else begin
                n_x[i+1] = r_x[i] - y_sh[i];
                n_y[i+1] = r_y[i] + x_sh[i];
            end
        end
        for (int i = 0; i < NS; i++) begin
            if (!r_y[i][XY_W-1]) begin
                n_z[i+1] = r_z[i] + $signed(atan_step(i));
            end else begin
                n_z[i+1] = r_z[i] - $signed(atan_step(i));
            end
        end
    end

    // Clamp z to [0, pi/2] and round it to the 2^-30 radian grid.
    always_comb begin
        if (r_z[NS][Z_W-1]) begin
            z_clip = '0;
        end else if (r_z[NS] > $signed(Z_MAX)) begin
            z_clip = Z_MAX;
        end else begin
            z_clip = r_z[NS];
        end
        z_rnd = z_clip + Z_ROUND;
    end

    // Radians to degrees, rounded half up, saturated at 90; axis cases bypass CORDIC.
    always_comb begin
        phi_sum = r_prod + PHI_ROUND;
        phi_raw = phi_sum[PROD_W-1:PHI_LSB];
        phi_sat = (phi_raw > PHI_90) ? PHI_90 : phi_raw;
        case (r_cls[NS+2].kind)
            KIND_GENERAL: n_phi = phi_sat;
            KIND_HORIZ:   n_phi = '0;
            KIND_VERT:    n_phi = PHI_90;
            KIND_ZERO:    n_phi = '0;
            default:      n_phi = '0;
        endcase
    end

    // Fold into the full circle and take bearing = 90 - theta in one add.
    always_comb begin
        phi_s = $signed(BR_W'(r_phi));
        if (!r_cls[NS+3].dy_neg && !r_cls[NS+3].dx_neg) begin
            br = B90 - phi_s;
        end else if (!r_cls[NS+3].dy_neg) begin
            br = phi_s - B90;
        end else if (r_cls[NS+3].dx_neg) begin
            br = -B90 - phi_s;
        end else begin
            br = phi_s - B270;
        end
        br_ext = EXT_W'(br);
        if (r_cls[NS+3].kind == KIND_ZERO) begin
            n_bearing = '0;
            n_invalid = 1'b1;
        end else begin
            n_bearing = br_ext[BEARING_W-1:0];
            n_invalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v         <= {r_v[NS+2:0], !i_empty};
            r_out_valid <= r_v[NS+3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x[0]   <= $signed({{(XY_W - AW){1'b0}}, i_ax} << PRESHIFT);
            r_y[0]   <= $signed({{(XY_W - AW){1'b0}}, i_ay} << PRESHIFT);
            r_z[0]   <= '0;
            r_cls[0] <= i_class;
            for (int i = 1; i < NS; i++) begin
                r_x[i] <= n_x[i];
                r_y[i] <= n_y[i];
            end
            for (int i = 1; i <= NS; i++) begin
                r_z[i] <= n_z[i];
            end
            for (int i = 1; i <= NS + 3; i++) begin
                r_cls[i] <= r_cls[i-1];
            end
            r_z30     <= z_rnd[Z30_W+Z30_SHIFT-1:Z30_SHIFT];
            r_prod    <= r_z30 * DEG_PER_RAD_Q26;
            r_phi     <= n_phi;
            r_bearing <= n_bearing;
            r_invalid <= n_invalid;
        end
    end

`ifndef SYNTH
    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_invalid |-> r_bearing == '0)
        else $error("invalid result carries a nonzero bearing");
    a_phi_in_quadrant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS+3] |-> r_phi <= PHI_90)
        else $error("first-quadrant angle exceeds 90 degrees");
`endif

endmodule

FILE: design/target_bearing_angle.sv
// Top level of the target bearing block: heading from the robot to a target point.
//
// Usage: i_coord delivers one word per valid/ready handshake holding the target and
// robot coordinates. For each word the block sends one word on o_bearing: bearing is
// 90 degrees minus the counterclockwise angle of (target - robot) from the +x axis, in
// units of 2^-ANGLE_FRAC_BITS degree, and invalid is set (with bearing 0) when target
// and robot coincide.
// The block accepts one word per cycle while o_bearing.ready stays high. A word is
// classified in the front register, waits in a four-entry queue, then runs through
// CORDIC_STAGES unrolled vectoring stages and four conversion stages.
// When the receiver holds o_bearing.ready low, the result register and the CORDIC
// pipeline hold still; the queue then absorbs up to four words and the front register
// one more before i_coord.ready drops.
// A synchronous active-low reset on i_rst_n empties the front register, the queue and
// all pipeline valid bits; no result is presented until new words arrive.
`timescale 1ns / 1ps

module target_bearing_angle import tba_pkg::*; #(
    parameter int CORDIC_STAGES   = 20,
    parameter int COORD_WIDTH     = 24,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tba_coord_if.sink     i_coord,
    tba_bearing_if.source o_bearing
);

    localparam int AW = COORD_WIDTH + 1;
    localparam int QW = 2 * AW + $bits(t_class);

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    logic [AW-1:0]   front_ax;
    logic [AW-1:0]   front_ay;
    t_class          front_class;
    logic [QW-1:0]   q_in;
    logic [QW-1:0]   q_out;
    logic [AW-1:0]   back_ax;
    logic [AW-1:0]   back_ay;
    t_class          back_class;

    // Front end: difference vector, magnitudes, quadrant and special-case class.
    tba_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coord (i_coord),
        .i_full  (full),
        .o_push  (push),
        .o_ax    (front_ax),
        .o_ay    (front_ay),
        .o_class (front_class)
    );

    // Queue word layout: class on top, then |dx|, then |dy|.
    assign q_in = {front_class, front_ax, front_ay};

    tba_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (empty)
    );

    assign back_class = t_class'(q_out[QW-1:2*AW]);
    assign back_ax    = q_out[2*AW-1:AW];
    assign back_ay    = q_out[AW-1:0];

    // Back end: CORDIC angle, conversion to degrees and folding into a bearing.
    tba_back #(
        .CORDIC_STAGES   (CORDIC_STAGES),
        .COORD_WIDTH     (COORD_WIDTH),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (empty),
        .i_ax      (back_ax),
        .i_ay      (back_ay),
        .i_class   (back_class),
        .o_pop     (pop),
        .o_bearing (o_bearing)
    );

endmodule

FILE: bench/tb_target_bearing_angle.sv
// Self-checking testbench for the target bearing block: random and directed coordinate words.
`timescale 1ns / 1ps

module tb_target_bearing_angle;
    import tba_pkg::*;

    localparam int STAGES  = 20;
    localparam int COORD_W = 24;
    localparam int FRAC    = 8;

    // Fixed-point constants of the bearing computation.
    localparam int              PRESHIFT     = 59 - COORD_W;
    localparam longint unsigned PI_Q60       = 64'h3243F6A8885A308D;
    localparam longint unsigned RAD2DEG_Q26  = 64'd3845054675;
    localparam longint unsigned QUARTER_TURN = 64'd90 << FRAC;
    localparam longint unsigned HALF_TURN    = 64'd180 << FRAC;
    localparam longint unsigned FULL_TURN    = 64'd360 << FRAC;

    localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W - 1){1'b1}}};
    localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W - 1){1'b0}}};

    localparam int RANDOM_WORDS = 1730;

    // One pending query word; hold makes the sender wait until every
    // outstanding result has come back before it offers this word.
    typedef struct {
        logic signed [COORD_W-1:0] tx;
        logic signed [COORD_W-1:0] ty;
        logic signed [COORD_W-1:0] rx;
        logic signed [COORD_W-1:0] ry;
        bit                        hold;
    } query_t;

    typedef struct packed {
        logic [BEARING_W-1:0] bearing;
        logic                 invalid;
    } bearing_word_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Everything the bench drives starts at a known value.
    logic   drv_valid = 1'b0;
    query_t drv_q     = '{tx: '0, ty: '0, rx: '0, ry: '0, hold: 1'b0};
    logic   rcv_ready = 1'b0;

    query_t        query_backlog[$];
    bearing_word_t bearing_due[$];
    int            words_sent  = 0;
    int            error_count = 0;

    tba_coord_if #(.COORD_WIDTH(COORD_W)) coord_ch ();
    tba_bearing_if bearing_ch ();

    assign coord_ch.valid    = drv_valid;
    assign coord_ch.target_x = drv_q.tx;
    assign coord_ch.target_y = drv_q.ty;
    assign coord_ch.robot_x  = drv_q.rx;
    assign coord_ch.robot_y  = drv_q.ry;
    assign bearing_ch.ready  = rcv_ready;

    target_bearing_angle #(
        .CORDIC_STAGES  (STAGES),
        .COORD_WIDTH    (COORD_W),
        .ANGLE_FRAC_BITS(FRAC)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_coord  (coord_ch.sink),
        .o_bearing(bearing_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // atan(2^-i) in radians scaled by 2^40. Stage zero is pi/4 taken from
    // pi at 2^60; the others sum the arctangent series at 2^60 with each
    // term truncated, then round to 2^40.
    function automatic longint arctan_q40(int i);
        longint unsigned sum;
        longint unsigned term;
        int              e;
        sum = 0;
        if (i == 0) begin
            return longint'((PI_Q60 + (64'd1 << 21)) >> 22);
        end
        for (int k = 0; k < 64; k++) begin
            e = 60 - i * (2 * k + 1);
            if (e < 0) begin
                break;
            end
            term = (64'd1 << e) / 64'(2 * k + 1);
            if (k % 2 == 1) begin
                sum -= term;
            end else begin
                sum += term;
            end
        end
        return longint'((sum + (64'd1 << 19)) >> 20);
    endfunction

    // Angle of (ax, ay) in the first quadrant, in 2^-FRAC degree. The caller
    // guarantees that the two magnitudes are not both zero.
    function automatic longint unsigned first_quadrant_angle(longint unsigned ax,
                                                             longint unsigned ay);
        longint          x;
        longint          y;
        longint          z;
        longint          xs;
        longint          ys;
        longint          zmax;
        longint unsigned z30;
        longint unsigned phi;
        if (ay == 0) begin
            return 0;
        end
        if (ax == 0) begin
            return QUARTER_TURN;
        end
        x = ax << PRESHIFT;
        y = ay << PRESHIFT;
        z = 0;
        // Vectoring: rotate toward the x axis, with floor-rounded shifts.
        for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys;
                y -= xs;
                z += arctan_q40(i);
            end else begin
                x -= ys;
                y += xs;
                z -= arctan_q40(i);
            end
        end
        zmax = longint'(PI_Q60 >> 21);
        if (z < 0) begin
            z = 0;
        end
        if (z > zmax) begin
            z = zmax;
        end
        z30 = (longint'(z) + 512) >> 10;
        phi = (z30 * RAD2DEG_Q26 + (64'd1 << (55 - FRAC))) >> (56 - FRAC);
        if (phi > QUARTER_TURN) begin
            phi = QUARTER_TURN;
        end
        return phi;
    endfunction

    // Bearing to the target: 90 degrees minus the counterclockwise angle of
    // the difference vector, folded from the first-quadrant angle.
    function automatic bearing_word_t heading_of(query_t q);
        longint          dx;
        longint          dy;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned phi;
        longint unsigned theta;
        longint          b;
        bearing_word_t   w;
        dx = longint'(q.tx) - longint'(q.rx);
        dy = longint'(q.ty) - longint'(q.ry);
        if (dx == 0 && dy == 0) begin
            w.bearing = '0;
            w.invalid = 1'b1;
            return w;
        end
        ax  = (dx < 0) ? -dx : dx;
        ay  = (dy < 0) ? -dy : dy;
        phi = first_quadrant_angle(ax, ay);
        // A dy of zero counts as the upper half plane.
        if (dy >= 0) begin
            theta = (dx >= 0) ? phi : HALF_TURN - phi;
        end else begin
            theta = (dx < 0) ? HALF_TURN + phi : FULL_TURN - phi;
        end
        b         = longint'(QUARTER_TURN) - longint'(theta);
        w.bearing = b[BEARING_W-1:0];
        w.invalid = 1'b0;
        return w;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic add_query(logic signed [COORD_W-1:0] tx, logic signed [COORD_W-1:0] ty,
                             logic signed [COORD_W-1:0] rx, logic signed [COORD_W-1:0] ry,
                             bit hold);
        query_t q;
        q.tx   = tx;
        q.ty   = ty;
        q.rx   = rx;
        q.ry   = ry;
        q.hold = hold;
        query_backlog.push_back(q);
    endtask

    function automatic logic signed [COORD_W-1:0] any_coord();
        logic [31:0] r;
        r = $urandom();
        return r[COORD_W-1:0];
    endfunction

    // A stretch of the run in which neither side idles.
    function automatic bit quiet_stretch();
        return words_sent >= 500 && words_sent < 800;
    endfunction

    // Sender: offers the next word from the backlog, idling now and then.
    // Each accepted word gets its expected result appended to bearing_due.
    always @(posedge i_clk) begin : drive_proc
        bit     go;
        query_t q;
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && coord_ch.ready) begin
                bearing_due.push_back(heading_of(drv_q));
                words_sent++;
            end
            if (!drv_valid || coord_ch.ready) begin
                go = query_backlog.size() != 0
                     && (quiet_stretch() || $urandom_range(0, 99) >= 10);
                // A held word waits until the pipeline has drained completely.
                if (go && query_backlog[0].hold && bearing_due.size() != 0) begin
                    go = 1'b0;
                end
                if (go) begin
                    q = query_backlog.pop_front();
                    drv_q     <= q;
                    drv_valid <= 1'b1;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks every accepted result against the oldest expected one
    // and stalls the block at random.
    always @(posedge i_clk) begin : watch_proc
        bearing_word_t want;
        if (!i_rst_n) begin
            rcv_ready <= 1'b0;
        end else begin
            if (bearing_ch.valid && rcv_ready) begin
                if (bearing_due.size() == 0) begin
                    report_mismatch("unexpected result word (bearing)",
                                    longint'(bearing_ch.bearing), 0);
                end else begin
                    want = bearing_due.pop_front();
                    if (bearing_ch.bearing !== want.bearing) begin
                        report_mismatch("bearing", longint'(bearing_ch.bearing),
                                        longint'($signed(want.bearing)));
                    end
                    if (bearing_ch.invalid !== want.invalid) begin
                        report_mismatch("invalid", longint'(bearing_ch.invalid),
                                        longint'(want.invalid));
                    end
                end
            end
            rcv_ready <= quiet_stretch() || $urandom_range(0, 99) >= 10;
        end
    end

    initial begin : stimulus
        logic signed [COORD_W-1:0] rx;
        logic signed [COORD_W-1:0] ry;
        logic signed [COORD_W-1:0] tx;
        logic signed [COORD_W-1:0] ty;
        int                        pick;
        int                        d;
        int                        e;
        bit                        hold;

        // Directed words: zero vectors, the axes, near-horizontal rounding,
        // the diagonals and the coordinate extremes.
        add_query('0, '0, '0, '0, 1'b0);
        add_query(CMAX, CMIN, CMAX, CMIN, 1'b0);
        add_query(CMIN, CMIN, CMIN, CMIN, 1'b0);
        add_query(CMAX, 5, CMIN, 5, 1'b0);
        add_query(CMIN, '0, CMAX, '0, 1'b0);
        add_query(3, CMAX, 3, CMIN, 1'b0);
        add_query(-3, CMIN, -3, CMAX, 1'b0);
        // Slightly negative dy with a long dx: the angle rounds to zero and
        // the bearing wraps to -270 degrees.
        add_query(CMAX, '0, CMIN, 1, 1'b0);
        add_query(CMIN, -1, CMAX, '0, 1'b0);
        add_query(1000, 1000, '0, '0, 1'b0);
        add_query(-1000, 1000, '0, '0, 1'b0);
        add_query(-1000, -1000, '0, '0, 1'b0);
        add_query(1000, -1000, '0, '0, 1'b0);
        add_query(1, '0, '0, '0, 1'b0);
        add_query('0, 1, '0, '0, 1'b0);
        add_query(1, 1, '0, '0, 1'b0);
        add_query('0, '0, 1, 1, 1'b0);
        add_query(1, -1, '0, '0, 1'b0);
        add_query(CMAX, CMAX, CMIN, CMIN, 1'b0);
        add_query(CMIN, CMIN, CMAX, CMAX, 1'b0);
        add_query(1, CMAX, '0, CMIN, 1'b0);
        add_query(-1, CMIN, '0, CMAX, 1'b0);
        add_query(CMAX, CMIN, CMIN, CMAX, 1'b0);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            hold = (n == 900) || (n == 1400);
            pick = $urandom_range(0, 99);
            rx   = any_coord();
            ry   = any_coord();
            if (pick < 55) begin
                tx = any_coord();
                ty = any_coord();
            end else if (pick < 75) begin
                // Target close to the robot.
                d  = int'($urandom_range(0, 510)) - 255;
                e  = int'($urandom_range(0, 510)) - 255;
                tx = COORD_W'(rx + d);
                ty = COORD_W'(ry + e);
            end else if (pick < 82) begin
                tx = rx;
                ty = ry;
            end else if (pick < 90) begin
                // Along one axis.
                if ($urandom_range(0, 1) == 1) begin
                    tx = rx;
                    ty = any_coord();
                end else begin
                    tx = any_coord();
                    ty = ry;
                end
            end else begin
                // Nearly along one axis, with a tiny cross component.
                d = int'($urandom_range(0, 6)) - 3;
                e = int'($urandom_range(1 << 20, (1 << 23) - 1));
                if ($urandom_range(0, 1) == 1) begin
                    e = -e;
                end
                if ($urandom_range(0, 1) == 1) begin
                    tx = COORD_W'(rx + e);
                    ty = COORD_W'(ry + d);
                end else begin
                    tx = COORD_W'(rx + d);
                    ty = COORD_W'(ry + e);
                end
            end
            add_query(tx, ty, rx, ry, hold);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (query_backlog.size() != 0 || drv_valid) begin
            @(posedge i_clk);
        end
        while (bearing_due.size() != 0) begin
            @(posedge i_clk);
        end
        // Let any stray result surface before the verdict.
        repeat (STAGES + 20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: target_bearing_angle.f
design/tba_pkg.sv
design/tba_coord_if.sv
design/tba_bearing_if.sv
design/tba_front.sv
design/tba_queue.sv
design/tba_back.sv
design/target_bearing_angle.sv
bench/tb_target_bearing_angle.sv
